/* rtl/espmd_pkg.sv */
// espmd_pkg: shared types, constants and the control store of the encoder speed pid drive
// no dependencies; imported by the top level
`default_nettype none

package espmd_pkg;

    // field and datapath widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 16;
    localparam int PULSE_W    = 16;
    localparam int MS_W       = 16;
    localparam int SCALE_W    = 24;
    localparam int SPEED_W    = 24;
    localparam int DERIV_W    = 25;
    localparam int SUM_W      = 40;
    localparam int SUM_SPLIT  = 20;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = 42;
    localparam int ACC_W      = 58;
    localparam int FRAC_W     = 8;
    localparam int DUTY_W     = 8;
    localparam int DRIVE_SHIFT = 16;

    // register reset values
    localparam logic [MS_W-1:0]    INTERVAL_RST = 16'd100;
    localparam logic [SCALE_W-1:0] SCALE_RST    = 24'd208050;
    localparam logic [DUTY_W-1:0]  DUTY_MAX     = 8'd255;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_RPM  = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_INTERVAL_MS = 3'd4,
        REG_SPEED_SCALE = 3'd5,
        REG_LOOP_ENABLE = 3'd6
    } t_reg_idx;

    // datapath action of one step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SAMPLE,
        OP_ELAPSED,
        OP_SPEED,
        OP_ERROR,
        OP_INTEG,
        OP_RESULT
    } t_dp_op;

    // multiplier operand selects
    typedef enum logic [1:0] {
        MA_PULSE,
        MA_GAIN_P,
        MA_GAIN_I,
        MA_GAIN_D
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_SCALE,
        MB_ERR,
        MB_DERIV,
        MB_SUM_HI,
        MB_SUM_LO
    } t_mul_b;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_ADD_HI
    } t_acc_op;

    // handshake the step waits on
    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_wait;

    // branch condition, taken means jump to target
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_NO_TICK,
        BR_NOT_DUE,
        BR_DISABLED
    } t_branch;

    // control store size and step addresses
    localparam int UC_DEPTH = 11;
    localparam int UC_PC_W  = $clog2(UC_DEPTH);
    typedef logic [UC_PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE    = t_pc'(0);
    localparam t_pc PC_ELAPSED = t_pc'(1);
    localparam t_pc PC_MUL_SPD = t_pc'(2);
    localparam t_pc PC_SPEED   = t_pc'(3);
    localparam t_pc PC_ERROR   = t_pc'(4);
    localparam t_pc PC_INTEG   = t_pc'(5);
    localparam t_pc PC_ACC_P   = t_pc'(6);
    localparam t_pc PC_ACC_D   = t_pc'(7);
    localparam t_pc PC_ACC_IH  = t_pc'(8);
    localparam t_pc PC_ACC_IL  = t_pc'(9);
    localparam t_pc PC_RESULT  = t_pc'(10);

    // one control word
    typedef struct packed {
        t_dp_op  op;
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        logic    mul_en;
        t_acc_op acc;
        t_wait   wait_on;
        t_branch br;
        t_pc     target;
    } t_uop;

    localparam t_uop UOP_NOP = '{
        op: OP_NONE, mul_a: MA_PULSE, mul_b: MB_SCALE, mul_en: 1'b0,
        acc: ACC_HOLD, wait_on: W_NONE, br: BR_NEXT, target: PC_IDLE
    };

    // control store: sample, interval check, speed, pid terms, result
    function automatic t_uop f_ucode(input t_pc pc);
        t_uop u;
        u = UOP_NOP;
        unique case (pc)
            PC_IDLE: begin
                u.op      = OP_SAMPLE;
                u.wait_on = W_IN;
                u.br      = BR_NO_TICK;
                u.target  = PC_IDLE;
            end
            PC_ELAPSED: begin
                u.op     = OP_ELAPSED;
                u.br     = BR_NOT_DUE;
                u.target = PC_ERROR;
            end
            PC_MUL_SPD: begin
                u.mul_a  = MA_PULSE;
                u.mul_b  = MB_SCALE;
                u.mul_en = 1'b1;
            end
            PC_SPEED: begin
                u.op = OP_SPEED;
            end
            PC_ERROR: begin
                u.op     = OP_ERROR;
                u.acc    = ACC_CLEAR;
                u.br     = BR_DISABLED;
                u.target = PC_RESULT;
            end
            PC_INTEG: begin
                u.op     = OP_INTEG;
                u.mul_a  = MA_GAIN_P;
                u.mul_b  = MB_ERR;
                u.mul_en = 1'b1;
            end
            PC_ACC_P: begin
                u.acc    = ACC_ADD;
                u.mul_a  = MA_GAIN_D;
                u.mul_b  = MB_DERIV;
                u.mul_en = 1'b1;
            end
            PC_ACC_D: begin
                u.acc    = ACC_ADD;
                u.mul_a  = MA_GAIN_I;
                u.mul_b  = MB_SUM_HI;
                u.mul_en = 1'b1;
            end
            PC_ACC_IH: begin
                u.acc    = ACC_ADD_HI;
                u.mul_a  = MA_GAIN_I;
                u.mul_b  = MB_SUM_LO;
                u.mul_en = 1'b1;
            end
            PC_ACC_IL: begin
                u.acc = ACC_ADD;
            end
            PC_RESULT: begin
                u.op      = OP_RESULT;
                u.wait_on = W_OUT;
                u.br      = BR_ALWAYS;
                u.target  = PC_IDLE;
            end
            default: begin
                u.br     = BR_ALWAYS;
                u.target = PC_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

/* rtl/espmd_enc_if.sv */
// espmd_enc_if: input channel carrying one encoder sample and the millisecond tick
// no dependencies
`default_nettype none

interface espmd_enc_if;
    logic valid;
    logic ready;
    logic enc_a;
    logic enc_b;
    logic ms_tick;

    modport source (output valid, output enc_a, output enc_b, output ms_tick, input ready);
    modport sink   (input valid, input enc_a, input enc_b, input ms_tick, output ready);
endinterface

`default_nettype wire

/* rtl/espmd_drv_if.sv */
// espmd_drv_if: result channel carrying the bridge duties and the measured speed
// no dependencies
`default_nettype none

interface espmd_drv_if;
    logic              valid;
    logic              ready;
    logic [7:0]        pwm_forward;
    logic [7:0]        pwm_reverse;
    logic signed [23:0] speed_rpm_q8;

    modport source (output valid, output pwm_forward, output pwm_reverse,
                    output speed_rpm_q8, input ready);
    modport sink   (input valid, input pwm_forward, input pwm_reverse,
                    input speed_rpm_q8, output ready);
endinterface

`default_nettype wire

/* rtl/encoder_speed_pid_motor_drive.sv */
// encoder_speed_pid_motor_drive: quadrature pulse counter, speed meter and pid drive
// depends on espmd_pkg, espmd_enc_if, espmd_drv_if
// a sample without tick returns to the idle step; a tick runs the control store through the interval
// check, speed, pid terms and result (longest when measuring with the loop on, one shared 17x25
// multiplier), result registered at the result step; next sample taken while a result waits
// synchronous active-low reset restores register defaults and clears all loop state
`default_nettype none

module encoder_speed_pid_motor_drive (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    espmd_enc_if.sink                          i_in,
    espmd_drv_if.source                        o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [espmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [espmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import espmd_pkg::*;

    localparam logic signed [PULSE_W-1:0] PULSE_MAX = {1'b0, {(PULSE_W-1){1'b1}}};
    localparam logic signed [PULSE_W-1:0] PULSE_MIN = {1'b1, {(PULSE_W-1){1'b0}}};

    // configuration registers
    logic signed [GAIN_W-1:0]  r_target, r_gain_p, r_gain_i, r_gain_d;
    logic [MS_W-1:0]           r_interval;
    logic [SCALE_W-1:0]        r_scale;
    logic                      r_enable;

    // loop state
    logic                      r_prev_a;
    logic signed [PULSE_W-1:0] r_pulse;
    logic [MS_W-1:0]           r_elapsed;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [SPEED_W-1:0] r_prior;
    logic signed [SUM_W-1:0]   r_sum;

    // datapath scratch
    logic signed [SPEED_W-1:0] r_err;
    logic signed [DERIV_W-1:0] r_deriv;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    // sequencer and result register
    t_pc                       r_pc, n_pc;
    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_pwm_fwd, r_pwm_rev;
    logic signed [SPEED_W-1:0] r_speed_out;

    t_uop                      w_uop;
    logic                      w_stall, w_exec;
    logic [MS_W:0]             w_elapsed_inc;
    logic                      w_due;
    logic signed [PROD_W-1:0]  w_speed_shift;
    logic signed [SPEED_W-1:0] w_speed_sat;
    logic signed [SPEED_W:0]   w_err_diff;
    logic signed [SPEED_W-1:0] w_err_sat;
    logic signed [SUM_W:0]     w_sum_next;
    logic signed [SUM_W-1:0]   w_sum_sat;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic                      w_neg;
    logic [ACC_W-1:0]          w_mag;
    logic [DUTY_W-1:0]         w_duty;

    // control word fetch and stall
    always_comb begin
        w_uop   = f_ucode(r_pc);
        w_stall = ((w_uop.wait_on == W_IN) && !i_in.valid) ||
                  ((w_uop.wait_on == W_OUT) && r_out_valid && !o_out.ready);
        w_exec  = !w_stall;
    end

    assign i_in.ready = (w_uop.wait_on == W_IN);

    // interval check
    always_comb begin
        w_elapsed_inc = {1'b0, r_elapsed} + {{MS_W{1'b0}}, 1'b1};
        w_due         = w_elapsed_inc > {1'b0, r_interval};
    end

    // next step
    always_comb begin
        n_pc = r_pc;
        if (w_exec) begin
            unique case (w_uop.br)
                BR_NEXT:     n_pc = r_pc + t_pc'(1);
                BR_ALWAYS:   n_pc = w_uop.target;
                BR_NO_TICK:  n_pc = !i_in.ms_tick ? w_uop.target : r_pc + t_pc'(1);
                BR_NOT_DUE:  n_pc = !w_due ? w_uop.target : r_pc + t_pc'(1);
                BR_DISABLED: n_pc = !r_enable ? w_uop.target : r_pc + t_pc'(1);
                default:     n_pc = PC_IDLE;
            endcase
        end
    end

    // speed: floor shift of the q.16 product and saturation
    always_comb begin
        w_speed_shift = r_prod >>> FRAC_W;
        if (w_speed_shift > PROD_W'(signed'({1'b0, {(SPEED_W-1){1'b1}}}))) begin
            w_speed_sat = {1'b0, {(SPEED_W-1){1'b1}}};
        end else if (w_speed_shift < -PROD_W'(signed'({1'b0, 1'b1, {(SPEED_W-1){1'b0}}}))) begin
            w_speed_sat = {1'b1, {(SPEED_W-1){1'b0}}};
        end else begin
            w_speed_sat = w_speed_shift[SPEED_W-1:0];
        end
    end

    // error against target, saturated
    always_comb begin
        w_err_diff = {r_speed[SPEED_W-1], r_speed} -
                     {r_target[GAIN_W-1], r_target, {FRAC_W{1'b0}}};
        if (w_err_diff[SPEED_W] != w_err_diff[SPEED_W-1]) begin
            w_err_sat = {w_err_diff[SPEED_W], {(SPEED_W-1){!w_err_diff[SPEED_W]}}};
        end else begin
            w_err_sat = w_err_diff[SPEED_W-1:0];
        end
    end

    // integral, saturated
    always_comb begin
        w_sum_next = {r_sum[SUM_W-1], r_sum} +
                     {{(SUM_W-SPEED_W+1){r_err[SPEED_W-1]}}, r_err};
        if (w_sum_next[SUM_W] != w_sum_next[SUM_W-1]) begin
            w_sum_sat = {w_sum_next[SUM_W], {(SUM_W-1){!w_sum_next[SUM_W]}}};
        end else begin
            w_sum_sat = w_sum_next[SUM_W-1:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (w_uop.mul_a)
            MA_PULSE:  w_mul_a = {r_pulse[PULSE_W-1], r_pulse};
            MA_GAIN_P: w_mul_a = {r_gain_p[GAIN_W-1], r_gain_p};
            MA_GAIN_I: w_mul_a = {r_gain_i[GAIN_W-1], r_gain_i};
            MA_GAIN_D: w_mul_a = {r_gain_d[GAIN_W-1], r_gain_d};
            default:   w_mul_a = '0;
        endcase
        unique case (w_uop.mul_b)
            MB_SCALE:  w_mul_b = {1'b0, r_scale};
            MB_ERR:    w_mul_b = {r_err[SPEED_W-1], r_err};
            MB_DERIV:  w_mul_b = r_deriv;
            MB_SUM_HI: w_mul_b = {{(MUL_B_W-SUM_SPLIT){r_sum[SUM_W-1]}},
                                  r_sum[SUM_W-1:SUM_SPLIT]};
            MB_SUM_LO: w_mul_b = {{(MUL_B_W-SUM_SPLIT){1'b0}}, r_sum[SUM_SPLIT-1:0]};
            default:   w_mul_b = '0;
        endcase
    end

    // drive: truncate toward zero, clamp to duty range
    always_comb begin
        w_neg  = r_acc[ACC_W-1];
        w_mag  = w_neg ? (~r_acc + ACC_W'(1)) : r_acc;
        w_duty = (|w_mag[ACC_W-1:DRIVE_SHIFT+DUTY_W]) ? DUTY_MAX
                                                       : w_mag[DRIVE_SHIFT+DUTY_W-1:DRIVE_SHIFT];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_interval <= INTERVAL_RST;
            r_scale    <= SCALE_RST;
            r_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TARGET_RPM:  r_target   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_P:      r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:      r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:      r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                REG_INTERVAL_MS: r_interval <= i_cfg_data[MS_W-1:0];
                REG_SPEED_SCALE: r_scale    <= i_cfg_data[SCALE_W-1:0];
                REG_LOOP_ENABLE: r_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_IDLE;
            r_prev_a  <= 1'b0;
            r_pulse   <= '0;
            r_elapsed <= '0;
            r_speed   <= '0;
            r_prior   <= '0;
            r_sum     <= '0;
        end else begin
            r_pc <= n_pc;
            if (w_exec) begin
                unique case (w_uop.op)
                    OP_SAMPLE: begin
                        // count a rising edge of channel a, direction from b
                        if (i_in.enc_a && !r_prev_a) begin
                            if (!i_in.enc_b && (r_pulse != PULSE_MAX)) begin
                                r_pulse <= r_pulse + PULSE_W'(1);
                            end else if (i_in.enc_b && (r_pulse != PULSE_MIN)) begin
                                r_pulse <= r_pulse - PULSE_W'(1);
                            end
                        end
                        r_prev_a <= i_in.enc_a;
                    end
                    OP_ELAPSED: begin
                        r_elapsed <= w_due ? '0 : w_elapsed_inc[MS_W-1:0];
                    end
                    OP_SPEED: begin
                        r_speed <= w_speed_sat;
                        r_pulse <= '0;
                    end
                    OP_INTEG: begin
                        r_sum   <= w_sum_sat;
                        r_prior <= r_err;
                    end
                    default: ;
                endcase
            end
        end
    end

    // scratch registers: error, derivative, product, accumulator
    always_ff @(posedge i_clk) begin
        if (w_exec && (w_uop.op == OP_ERROR)) begin
            r_err <= w_err_sat;
        end
        if (w_exec && (w_uop.op == OP_INTEG)) begin
            r_deriv <= {r_err[SPEED_W-1], r_err} - {r_prior[SPEED_W-1], r_prior};
        end
        if (w_uop.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        unique case (w_uop.acc)
            ACC_HOLD:   r_acc <= r_acc;
            ACC_CLEAR:  r_acc <= '0;
            ACC_ADD:    r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ACC_ADD_HI: r_acc <= r_acc + {r_prod[ACC_W-SUM_SPLIT-1:0], {SUM_SPLIT{1'b0}}};
            default:    r_acc <= r_acc;
        endcase
    end

    // result register, loaded when free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec && (w_uop.op == OP_RESULT)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload held with the result so a later measurement cannot disturb it
    always_ff @(posedge i_clk) begin
        if (w_exec && (w_uop.op == OP_RESULT)) begin
            r_pwm_fwd   <= w_neg ? '0 : w_duty;
            r_pwm_rev   <= w_neg ? w_duty : '0;
            r_speed_out <= r_speed;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pwm_forward  = r_pwm_fwd;
    assign o_out.pwm_reverse  = r_pwm_rev;
    assign o_out.speed_rpm_q8 = r_speed_out;

endmodule

`default_nettype wire
